[rtl/core/rlh_pkg.sv]
package rlh_pkg;

    // Sizes of the stores
    localparam int RINGS     = 8;
    localparam int BINS      = 1024;
    localparam int RING_AW   = (RINGS > 1) ? $clog2(RINGS) : 1;
    localparam int DEPTH     = RINGS * BINS;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int LAT_W     = $clog2(BINS);

    // Field widths fixed by the interface
    localparam int TIME_W    = 64;
    localparam int CNT_W     = 32;
    localparam int CPN_W     = 8;
    localparam int INT_W     = 48;
    localparam int RING_W    = 3;
    localparam int BIN_IDX_W = 10;
    localparam int LIM_W     = LAT_W + CPN_W;

    // Configuration register indexes
    localparam logic REG_CPN      = 1'b0;
    localparam logic REG_INTERVAL = 1'b1;

    typedef enum logic [1:0] {
        ACT_STAMP   = 2'd0,
        ACT_MEASURE = 2'd1,
        ACT_READ    = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    typedef enum logic [7:0] {
        ST_CLEAR  = 8'b0000_0001,
        ST_IDLE   = 8'b0000_0010,
        ST_PREP   = 8'b0000_0100,
        ST_STAMP  = 8'b0000_1000,
        ST_DIV    = 8'b0001_0000,
        ST_HREAD  = 8'b0010_0000,
        ST_HWRITE = 8'b0100_0000,
        ST_RDOUT  = 8'b1000_0000
    } state_t;

    typedef enum logic [2:0] {
        DV_IDLE  = 3'b001,
        DV_CHECK = 3'b010,
        DV_RUN   = 3'b100
    } div_state_t;

    // Flat histogram address of one bin of one ring
    function automatic logic [ADDR_W-1:0] hist_addr(input logic [RING_AW-1:0] r,
                                                    input logic [LAT_W-1:0] b);
        return ADDR_W'(int'(r) * BINS + int'(b));
    endfunction

endpackage

[rtl/core/ring_latency_histogram_top.sv]
// Channel   Handshake          Fields
// command   start / busy       action ring now pkt_timestamp bin_index burst_last
// result    done (one cycle)   stamped timestamp_out counted latency_bin bin_count burst_end
// config    cfg_we             cfg_index cfg_data
//
// One item at a time. Stamp items pass through PREP and STAMP, read items
// through PREP and RDOUT; no-op and unstamped measure items finish in PREP.
// Measure items pass through PREP, DIV, HREAD and HWRITE; in DIV a latency
// past the last bin is clamped, else the one-bit-per-cycle divider runs.
// After reset the histogram memory is cleared, one entry a cycle, all
// RINGS * BINS (8192) entries, with busy high. Results cannot be stalled.
module ring_latency_histogram_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        action,
    input  logic [rlh_pkg::RING_W-1:0]        ring,
    input  logic [rlh_pkg::TIME_W-1:0]        now,
    input  logic [rlh_pkg::TIME_W-1:0]        pkt_timestamp,
    input  logic [rlh_pkg::BIN_IDX_W-1:0]     bin_index,
    input  logic                              burst_last,
    output logic                              done,
    output logic                              stamped,
    output logic [rlh_pkg::TIME_W-1:0]        timestamp_out,
    output logic                              counted,
    output logic [rlh_pkg::BIN_IDX_W-1:0]     latency_bin,
    output logic [rlh_pkg::CNT_W-1:0]         bin_count,
    output logic                              burst_end,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [rlh_pkg::INT_W-1:0]         cfg_data
);

    rlh_pkg::state_t                   state_reg, state_next;
    logic [rlh_pkg::CPN_W-1:0]         cpn_reg;
    logic [rlh_pkg::INT_W-1:0]         interval_reg;
    logic [rlh_pkg::ADDR_W-1:0]        clr_reg;

    rlh_pkg::action_t                  act_reg;
    logic [rlh_pkg::RING_W-1:0]        ring_reg;
    logic [rlh_pkg::TIME_W-1:0]        now_reg;
    logic [rlh_pkg::TIME_W-1:0]        ts_reg;
    logic [rlh_pkg::BIN_IDX_W-1:0]     bin_reg;
    logic                              burst_reg;
    logic [rlh_pkg::TIME_W-1:0]        sum_reg;
    logic [rlh_pkg::LAT_W-1:0]         q_reg;

    logic [rlh_pkg::TIME_W-1:0]        prev_reg  [rlh_pkg::RINGS];
    logic [rlh_pkg::TIME_W-1:0]        timer_reg [rlh_pkg::RINGS];

    logic                              done_reg;
    logic                              stamped_reg;
    logic [rlh_pkg::TIME_W-1:0]        ts_out_reg;
    logic                              counted_reg;
    logic [rlh_pkg::BIN_IDX_W-1:0]     lbin_reg;
    logic [rlh_pkg::CNT_W-1:0]         count_reg;
    logic                              burst_out_reg;

    logic [rlh_pkg::RING_AW-1:0]       ridx;
    logic                              ring_ok;
    logic                              bin_ok;
    logic                              div_start;
    logic                              div_done;
    logic [rlh_pkg::LAT_W-1:0]         div_quot;
    logic [rlh_pkg::CPN_W-1:0]         divisor;

    logic                              ram_we;
    logic [rlh_pkg::ADDR_W-1:0]        ram_addr;
    logic [rlh_pkg::CNT_W-1:0]         ram_wdata;
    logic [rlh_pkg::CNT_W-1:0]         ram_rdata;

    assign ridx    = rlh_pkg::RING_AW'(ring_reg);
    assign ring_ok = int'(ring_reg) < rlh_pkg::RINGS;
    assign bin_ok  = int'(bin_reg) < rlh_pkg::BINS;
    assign divisor = (cpn_reg == '0) ? rlh_pkg::CPN_W'(1) : cpn_reg;
    assign div_start = (state_reg == rlh_pkg::ST_PREP) && ring_ok &&
                       (act_reg == rlh_pkg::ACT_MEASURE) && (ts_reg != '0);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rlh_pkg::ST_CLEAR:
            begin
                if (clr_reg == rlh_pkg::ADDR_W'(rlh_pkg::DEPTH - 1))
                begin
                    state_next = rlh_pkg::ST_IDLE;
                end
            end
            rlh_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = rlh_pkg::ST_PREP;
                end
            end
            rlh_pkg::ST_PREP:
            begin
                state_next = rlh_pkg::ST_IDLE;
                if (ring_ok)
                begin
                    case (act_reg)
                        rlh_pkg::ACT_STAMP:   state_next = rlh_pkg::ST_STAMP;
                        rlh_pkg::ACT_MEASURE:
                        begin
                            if (ts_reg != '0)
                            begin
                                state_next = rlh_pkg::ST_DIV;
                            end
                        end
                        rlh_pkg::ACT_READ:
                        begin
                            if (bin_ok)
                            begin
                                state_next = rlh_pkg::ST_RDOUT;
                            end
                        end
                        default:              state_next = rlh_pkg::ST_IDLE;
                    endcase
                end
            end
            rlh_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = rlh_pkg::ST_HREAD;
                end
            end
            rlh_pkg::ST_HREAD:  state_next = rlh_pkg::ST_HWRITE;
            rlh_pkg::ST_HWRITE: state_next = rlh_pkg::ST_IDLE;
            rlh_pkg::ST_STAMP:  state_next = rlh_pkg::ST_IDLE;
            rlh_pkg::ST_RDOUT:  state_next = rlh_pkg::ST_IDLE;
            default:            state_next = rlh_pkg::ST_IDLE;
        endcase
    end

    // Histogram memory port: clear sweep, bin read, increment write-back
    always_comb
    begin
        ram_we    = 1'b0;
        ram_wdata = ram_rdata + 1'b1;
        ram_addr  = rlh_pkg::hist_addr(ridx, q_reg);
        unique case (state_reg)
            rlh_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                ram_addr  = clr_reg;
            end
            rlh_pkg::ST_PREP:
            begin
                ram_addr = rlh_pkg::hist_addr(ridx, rlh_pkg::LAT_W'(bin_reg));
            end
            rlh_pkg::ST_HWRITE:
            begin
                ram_we = 1'b1;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Control, ring state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= rlh_pkg::ST_CLEAR;
            clr_reg      <= '0;
            cpn_reg      <= rlh_pkg::CPN_W'(1);
            interval_reg <= '0;
            done_reg     <= 1'b0;
            for (int i = 0; i < rlh_pkg::RINGS; i++)
            begin
                prev_reg[i]  <= '0;
                timer_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= 1'b0;

            if (cfg_we)
            begin
                case (cfg_index)
                    rlh_pkg::REG_CPN:      cpn_reg      <= cfg_data[rlh_pkg::CPN_W-1:0];
                    rlh_pkg::REG_INTERVAL: interval_reg <= cfg_data;
                    default:               cpn_reg      <= cpn_reg;
                endcase
            end

            if (state_reg == rlh_pkg::ST_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end

            // Capture the command beat
            if (state_reg == rlh_pkg::ST_IDLE && start)
            begin
                act_reg   <= rlh_pkg::action_t'(action);
                ring_reg  <= ring;
                now_reg   <= now;
                ts_reg    <= pkt_timestamp;
                bin_reg   <= bin_index;
                burst_reg <= burst_last;
            end

            // Default result fields for this beat
            if (state_reg == rlh_pkg::ST_PREP)
            begin
                stamped_reg   <= 1'b0;
                ts_out_reg    <= ts_reg;
                counted_reg   <= 1'b0;
                lbin_reg      <= '0;
                count_reg     <= '0;
                burst_out_reg <= burst_reg;
                sum_reg       <= timer_reg[ridx] + (now_reg - prev_reg[ridx]);
                if (state_next == rlh_pkg::ST_IDLE)
                begin
                    done_reg <= 1'b1;
                end
            end

            // Sample timer update
            if (state_reg == rlh_pkg::ST_STAMP)
            begin
                prev_reg[ridx] <= now_reg;
                if (sum_reg >= rlh_pkg::TIME_W'(interval_reg))
                begin
                    timer_reg[ridx] <= '0;
                    stamped_reg     <= 1'b1;
                    ts_out_reg      <= now_reg;
                end
                else
                begin
                    timer_reg[ridx] <= sum_reg;
                end
                done_reg <= 1'b1;
            end

            if (state_reg == rlh_pkg::ST_DIV && div_done)
            begin
                q_reg <= div_quot;
            end

            if (state_reg == rlh_pkg::ST_HWRITE)
            begin
                counted_reg <= 1'b1;
                lbin_reg    <= rlh_pkg::BIN_IDX_W'(q_reg);
                done_reg    <= 1'b1;
            end

            if (state_reg == rlh_pkg::ST_RDOUT)
            begin
                count_reg <= ram_rdata;
                done_reg  <= 1'b1;
            end
        end
    end

    rlh_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .diff    (now_reg - ts_reg),
        .divisor (divisor),
        .done    (div_done),
        .quot    (div_quot)
    );

    rlh_ram #(
        .WIDTH (rlh_pkg::CNT_W),
        .DEPTH (rlh_pkg::DEPTH)
    ) u_hist (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign busy          = (state_reg != rlh_pkg::ST_IDLE);
    assign done          = done_reg;
    assign stamped       = stamped_reg;
    assign timestamp_out = ts_out_reg;
    assign counted       = counted_reg;
    assign latency_bin   = lbin_reg;
    assign bin_count     = count_reg;
    assign burst_end     = burst_out_reg;

endmodule

[rtl/core/rlh_ram.sv]
module rlh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[rtl/core/rlh_div.sv]
module rlh_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [rlh_pkg::TIME_W-1:0]        diff,
    input  logic [rlh_pkg::CPN_W-1:0]         divisor,
    output logic                              done,
    output logic [rlh_pkg::LAT_W-1:0]         quot
);

    localparam int STEP_W = (rlh_pkg::LAT_W > 1) ? $clog2(rlh_pkg::LAT_W) : 1;

    rlh_pkg::div_state_t              state_reg;
    logic [rlh_pkg::TIME_W-1:0]       diff_reg;
    logic [rlh_pkg::CPN_W-1:0]        d_reg;
    logic [rlh_pkg::LIM_W-1:0]        limit_reg;
    logic [rlh_pkg::CPN_W-1:0]        rem_reg;
    logic [rlh_pkg::LAT_W-1:0]        dvd_reg;
    logic [STEP_W-1:0]                step_reg;
    logic                             done_reg;
    logic [rlh_pkg::LAT_W-1:0]        quot_reg;

    logic [rlh_pkg::CPN_W:0]          trial;
    logic                             ge;
    logic [rlh_pkg::CPN_W:0]          trial_sub;

    // One restoring step: bring down the next dividend bit
    assign trial     = {rem_reg, dvd_reg[rlh_pkg::LAT_W-1]};
    assign ge        = trial >= {1'b0, d_reg};
    assign trial_sub = trial - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rlh_pkg::DV_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                rlh_pkg::DV_IDLE:
                begin
                    if (start)
                    begin
                        diff_reg  <= diff;
                        d_reg     <= divisor;
                        limit_reg <= rlh_pkg::LIM_W'(divisor) *
                                     rlh_pkg::LIM_W'(rlh_pkg::BINS - 1);
                        state_reg <= rlh_pkg::DV_CHECK;
                    end
                end
                rlh_pkg::DV_CHECK:
                begin
                    // Past the last bin: clamp without iterating
                    if (diff_reg >= rlh_pkg::TIME_W'(limit_reg))
                    begin
                        quot_reg  <= rlh_pkg::LAT_W'(rlh_pkg::BINS - 1);
                        done_reg  <= 1'b1;
                        state_reg <= rlh_pkg::DV_IDLE;
                    end
                    else
                    begin
                        // high part is below the divisor here
                        rem_reg   <= diff_reg[rlh_pkg::LIM_W-1:rlh_pkg::LAT_W];
                        dvd_reg   <= diff_reg[rlh_pkg::LAT_W-1:0];
                        step_reg  <= '0;
                        state_reg <= rlh_pkg::DV_RUN;
                    end
                end
                rlh_pkg::DV_RUN:
                begin
                    rem_reg  <= ge ? trial_sub[rlh_pkg::CPN_W-1:0]
                                   : trial[rlh_pkg::CPN_W-1:0];
                    dvd_reg  <= {dvd_reg[rlh_pkg::LAT_W-2:0], ge};
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(rlh_pkg::LAT_W - 1))
                    begin
                        quot_reg  <= {dvd_reg[rlh_pkg::LAT_W-2:0], ge};
                        done_reg  <= 1'b1;
                        state_reg <= rlh_pkg::DV_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= rlh_pkg::DV_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

[rtl/core/rlh_checker.sv]
module rlh_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        done,
    input logic                        stamped,
    input logic                        counted,
    input logic [rlh_pkg::CNT_W-1:0]   bin_count
);

    // A result beat only follows work in progress
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result beat without a command in progress");

    // An accepted command makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command accepted but block not busy");

    // Stamp and measure never both report
    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(stamped && counted))
        else $error("stamped and counted in one beat");

    // A measure beat carries no bin count
    a_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && counted) |-> (bin_count == '0))
        else $error("bin count on a measure beat");

endmodule

bind ring_latency_histogram_top rlh_checker u_rlh_checker (.*);

[tb/sv/ring_latency_histogram_top_tb.sv]
`timescale 1ns / 1ps

module ring_latency_histogram_top_tb;
    import rlh_pkg::*;

    typedef struct packed {
        logic [1:0]           act;
        logic [RING_W-1:0]    rng;
        logic [TIME_W-1:0]    t_now;
        logic [TIME_W-1:0]    ts;
        logic [BIN_IDX_W-1:0] bidx;
        logic                 blast;
    } cmd_t;

    typedef struct packed {
        logic                 stamped;
        logic [TIME_W-1:0]    ts_out;
        logic                 counted;
        logic [BIN_IDX_W-1:0] lbin;
        logic [CNT_W-1:0]     count;
        logic                 bend;
    } res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [1:0] action = '0;
    logic [RING_W-1:0] ring = '0;
    logic [TIME_W-1:0] now = '0;
    logic [TIME_W-1:0] pkt_timestamp = '0;
    logic [BIN_IDX_W-1:0] bin_index = '0;
    logic burst_last = 1'b0;
    logic done;
    logic stamped;
    logic [TIME_W-1:0] timestamp_out;
    logic counted;
    logic [BIN_IDX_W-1:0] latency_bin;
    logic [CNT_W-1:0] bin_count;
    logic burst_end;
    logic cfg_we = 1'b0;
    logic cfg_index = 1'b0;
    logic [INT_W-1:0] cfg_data = '0;

    ring_latency_histogram_top dut (.*);

    always #2 clk = ~clk;

    // predictor state
    logic [CPN_W-1:0]  cur_cpn;
    logic [INT_W-1:0]  cur_interval;
    logic [TIME_W-1:0] last_seen [RINGS];
    logic [TIME_W-1:0] gap_timer [RINGS];
    logic [CNT_W-1:0]  hist [RINGS][BINS];

    cmd_t pending_cmds [$];
    res_t expected_results [$];
    int   mismatches = 0;
    int   idle_cycles = 0;
    bit   quiet_tail = 0;
    bit   timed_out = 0;
    int   gap_left = 0;

    function automatic res_t histogram_step(cmd_t c);
        res_t r;
        logic [TIME_W-1:0] lat;
        logic [TIME_W-1:0] dv;
        r = '0;
        r.ts_out = c.ts;
        r.bend = c.blast;
        if (int'(c.rng) < RINGS) begin
            case (action_t'(c.act))
                ACT_STAMP:
                begin
                    gap_timer[c.rng] = gap_timer[c.rng] + (c.t_now - last_seen[c.rng]);
                    if (gap_timer[c.rng] >= TIME_W'(cur_interval))
                    begin
                        r.stamped = 1'b1;
                        r.ts_out = c.t_now;
                        gap_timer[c.rng] = '0;
                    end
                    last_seen[c.rng] = c.t_now;
                end
                ACT_MEASURE:
                begin
                    if (c.ts != 0)
                    begin
                        dv = (cur_cpn == 0) ? 1 : TIME_W'(cur_cpn);
                        lat = (c.t_now - c.ts) / dv;
                        if (lat >= BINS - 1)
                            lat = BINS - 1;
                        hist[c.rng][lat] = hist[c.rng][lat] + 1;
                        r.counted = 1'b1;
                        r.lbin = lat[BIN_IDX_W-1:0];
                    end
                end
                ACT_READ:
                begin
                    if (int'(c.bidx) < BINS)
                        r.count = hist[c.rng][c.bidx];
                end
                default: ;
            endcase
        end
        return r;
    endfunction

    // driver: one beat per accepted command, random gaps
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                expected_results.push_back(histogram_step(pending_cmds.pop_front()));
                start <= 1'b0;
                if (!quiet_tail && $urandom_range(0, 3) == 0)
                    gap_left = $urandom_range(1, 3);
            end
            else if (!start && pending_cmds.size() > 0)
            begin
                if (gap_left > 0)
                    gap_left--;
                else
                begin
                    action <= pending_cmds[0].act;
                    ring <= pending_cmds[0].rng;
                    now <= pending_cmds[0].t_now;
                    pkt_timestamp <= pending_cmds[0].ts;
                    bin_index <= pending_cmds[0].bidx;
                    burst_last <= pending_cmds[0].blast;
                    start <= 1'b1;
                end
            end
        end
    end

    // monitor and watchdog
    always @(posedge clk)
    begin
        res_t e;
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat");
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (e !== {stamped, timestamp_out, counted, latency_bin, bin_count,
                               burst_end})
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp st=%0d ts=%h cn=%0d bin=%0d cnt=%0d be=%0d"
                                     , e.stamped, e.ts_out, e.counted, e.lbin, e.count, e.bend,
                                     "\n          got st=%0d ts=%h cn=%0d bin=%0d cnt=%0d be=%0d"
                                     , stamped, timestamp_out, counted, latency_bin,
                                     bin_count, burst_end);
                    end
                end
            end
            if (idle_cycles > 40000)
                timed_out = 1;
        end
    end

    function automatic logic [TIME_W-1:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic add_cmd(logic [1:0] a, logic [RING_W-1:0] r, logic [TIME_W-1:0] n,
                           logic [TIME_W-1:0] t, logic [BIN_IDX_W-1:0] b);
        cmd_t c;
        c.act = a;
        c.rng = r;
        c.t_now = n;
        c.ts = t;
        c.bidx = b;
        c.blast = $urandom_range(0, 1);
        pending_cmds.push_back(c);
    endtask

    task automatic write_reg(logic idx, logic [INT_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == REG_CPN)
            cur_cpn = val[CPN_W-1:0];
        else
            cur_interval = val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while ((pending_cmds.size() > 0 || expected_results.size() > 0) && !timed_out)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    // random phase: one shared timeline so latencies land across the bins
    task automatic random_phase(int n);
        logic [TIME_W-1:0] clock_now;
        logic [TIME_W-1:0] t;
        int k;
        clock_now = $urandom_range(0, 100000);
        for (int i = 0; i < n; i++)
        begin
            clock_now = clock_now + $urandom_range(0, 5000);
            k = $urandom_range(0, 19);
            if (k < 7)
                add_cmd(ACT_STAMP, $urandom, clock_now, rand64(), $urandom);
            else if (k < 14)
            begin
                t = clock_now - $urandom_range(0, 3000);
                if ($urandom_range(0, 9) == 0)
                    t = 0;
                add_cmd(ACT_MEASURE, $urandom, clock_now, t, $urandom);
            end
            else if (k < 18)
                add_cmd(ACT_READ, $urandom, rand64(), rand64(), $urandom_range(0, 40));
            else if (k < 19)
                add_cmd($urandom, $urandom, rand64(), rand64(), $urandom);
            else
                add_cmd(ACT_READ, $urandom, rand64(), rand64(), $urandom);
        end
    endtask

    initial
    begin
        cur_cpn = 1;
        cur_interval = 0;
        foreach (last_seen[r])
        begin
            last_seen[r] = '0;
            gap_timer[r] = '0;
            foreach (hist[r][b])
                hist[r][b] = '0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, every action, zero timestamp, future timestamp
        add_cmd(ACT_STAMP, 0, '1, 0, 0);
        add_cmd(ACT_STAMP, 7, 0, '1, '1);
        add_cmd(ACT_MEASURE, 0, 100, 0, 0);
        add_cmd(ACT_MEASURE, 0, 100, 90, 0);
        add_cmd(ACT_MEASURE, 7, 5000, 4000, 0);
        add_cmd(ACT_MEASURE, 3, 10, 20, 0);
        add_cmd(ACT_MEASURE, 3, '1, 1, 0);
        add_cmd(ACT_MEASURE, 3, 1023, 1, 0);
        add_cmd(ACT_READ, 0, 0, 0, 10);
        add_cmd(ACT_READ, 3, 0, 0, BINS - 1);
        add_cmd(ACT_READ, 3, 0, 0, BINS - 2);
        add_cmd(ACT_READ, 7, '1, '1, 0);
        add_cmd(ACT_NONE, 2, '1, '1, '1);
        drain();

        write_reg(REG_CPN, 0);
        write_reg(REG_INTERVAL, '1);
        add_cmd(ACT_MEASURE, 1, 300, 100, 0);
        add_cmd(ACT_STAMP, 1, 50, 7, 0);
        add_cmd(ACT_STAMP, 1, '1, 7, 0);
        add_cmd(ACT_READ, 1, 0, 0, 200);
        drain();

        write_reg(REG_CPN, 255);
        write_reg(REG_INTERVAL, 2000);
        add_cmd(ACT_MEASURE, 2, 300000, 100, 0);
        add_cmd(ACT_MEASURE, 2, 2000, 100, 0);
        add_cmd(ACT_READ, 2, 0, 0, 7);
        drain();

        // random phases across settings
        write_reg(REG_CPN, 1);
        write_reg(REG_INTERVAL, 0);
        random_phase(400);
        drain();
        write_reg(REG_CPN, 3);
        write_reg(REG_INTERVAL, 6000);
        random_phase(400);
        drain();
        write_reg(REG_CPN, INT_W'($urandom_range(1, 255)));
        write_reg(REG_INTERVAL, INT_W'({$urandom, $urandom}));
        random_phase(400);
        drain();
        write_reg(REG_CPN, 2);
        write_reg(REG_INTERVAL, 15000);
        quiet_tail = 1;
        random_phase(400);
        drain();

        if (timed_out)
            $display("Simulation FAILED");
        else if (mismatches == 0 && expected_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
